// ===== design/cjd_pkg.sv =====
// constants shared by the calendar to julian date unit
`timescale 1ns / 1ps
package cjd_pkg;

  localparam int YEAR_W  = 14;
  localparam int DAY_W   = 23;
  localparam int MS_W    = 27;

  localparam logic [13:0] YEAR_MIN = 14'd1;
  localparam logic [13:0] YEAR_MAX = 14'd9999;

  localparam logic [14:0] YEAR_OFFSET = 15'd4716;
  localparam logic [24:0] DAYS_PER_4Y = 25'd1461;
  // floor(n * 5243 / 2^19) equals floor(n / 100) for every year in range
  localparam logic [25:0] CENTURY_RECIP = 26'd5243;
  localparam logic [23:0] DAY_BIAS = 24'd1522;

  localparam logic [MS_W-1:0] HOUR_MS   = 27'd3600000;
  localparam logic [MS_W-1:0] MINUTE_MS = 27'd60000;
  localparam logic [MS_W:0]   DAY_MS    = 28'd86400000;

  // scale of the reciprocal of a day in milliseconds, exact for every remainder
  localparam int RECIP_SHIFT = 44;

  localparam logic [54:0] OUT_MAX = {55{1'b1}};

  // floor(30.6001 * (m + 1)), january and february already moved to 13 and 14
  localparam logic [8:0] MONTH_TERM [16] = '{
    9'd30,  9'd428, 9'd459, 9'd122, 9'd153, 9'd183, 9'd214, 9'd244,
    9'd275, 9'd306, 9'd336, 9'd367, 9'd397, 9'd428, 9'd459, 9'd489
  };

endpackage

// ===== design/calendar_to_julian_date_unit.sv =====
// calendar_to_julian_date_unit: gregorian date and time of day to fixed-point julian date
`timescale 1ns / 1ps
// Usage
//   Input channel: in_valid / in_stall with year_number, month_number, day_of_month,
//   hour_of_day, minute_of_hour and milli_of_minute. A beat is taken at a rising
//   edge with in_valid high and in_stall low.
//   Output channel: out_valid / out_stall with julian_date_fixed, the julian date
//   times 2^FRACTION_BITS, fraction truncated, saturated at 2^55-1.
//   Throughput: one beat per cycle while out_stall is low. Three stages build
//   the whole day count and the remainder of milliseconds, the third also
//   forms two halves of the remainder times a reciprocal of the day length, a
//   fourth adds them to give the fraction, and a last stage joins and saturates.
//   Reset (rst, synchronous) empties every stage; out_valid drops at once.
//   When the receiver stalls, the output beat holds and the stages behind it
//   keep moving until they fill; in_stall rises only once the whole chain is full.
module calendar_to_julian_date_unit #(
  parameter int FRACTION_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [13:0] year_number,
  input  logic [3:0]  month_number,
  input  logic [4:0]  day_of_month,
  input  logic [4:0]  hour_of_day,
  input  logic [5:0]  minute_of_hour,
  input  logic [15:0] milli_of_minute,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [54:0] julian_date_fixed
);
  import cjd_pkg::*;

  localparam int NS = 5;
  localparam int VW = DAY_W + FRACTION_BITS;
  localparam int CW = (VW > 55) ? VW : 56;
  localparam int MW = FRACTION_BITS + 18;
  localparam int MLO_W = MW / 2;
  localparam int MHI_W = MW - MLO_W;
  localparam int RW = RECIP_SHIFT + FRACTION_BITS + 1;
  localparam int PLO_W = MS_W + MLO_W;
  localparam int PHI_W = MS_W + MHI_W;
  localparam int PW = MS_W + MW;
  localparam logic [RW-1:0] RECIP_FULL =
    ((RW'(1) << (RECIP_SHIFT + FRACTION_BITS)) + RW'(DAY_MS) - RW'(1)) / RW'(DAY_MS);
  localparam logic [MLO_W-1:0] RECIP_LO = RECIP_FULL[MLO_W-1:0];
  localparam logic [MHI_W-1:0] RECIP_HI = RECIP_FULL[MW-1:MLO_W];

  logic [NS-1:0] v;
  logic [NS:0]   en;

  logic [YEAR_W-1:0] s1_year;
  logic [9:0]        s1_md;
  logic [MS_W-1:0]   s1_ms;

  logic [DAY_W-1:0]  s2_yterm;
  logic [6:0]        s2_cent;
  logic [9:0]        s2_md;
  logic              s2_whole;
  logic [MS_W-1:0]   s2_rem;

  logic [DAY_W-1:0]  s3_day;
  logic [PLO_W-1:0]  s3_plo;
  logic [PHI_W-1:0]  s3_phi;

  logic [DAY_W-1:0]         s4_day;
  logic [FRACTION_BITS-1:0] s4_frac;

  logic [54:0] out_data;

  // handshake: a stage loads when it is empty or the next one moves
  always_comb begin
    en[NS] = !out_stall;
    for (int i = NS - 1; i >= 0; i--) begin
      en[i] = !v[i] || en[i+1];
    end
  end

  assign in_stall          = !en[0];
  assign out_valid         = v[NS-1];
  assign julian_date_fixed = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= in_valid;
      end
      for (int i = 1; i < NS; i++) begin
        if (en[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  // stage 1: clamp year, month shift, month term, milliseconds of day
  logic [YEAR_W-1:0] year_clamp;
  logic [YEAR_W-1:0] year_adj;
  logic              early_month;
  logic [MS_W-1:0]   ms_total;

  always_comb begin
    if (year_number < YEAR_MIN) begin
      year_clamp = YEAR_MIN;
    end else if (year_number > YEAR_MAX) begin
      year_clamp = YEAR_MAX;
    end else begin
      year_clamp = year_number;
    end
    early_month = (month_number == 4'd1) || (month_number == 4'd2);
    year_adj    = early_month ? year_clamp - 14'd1 : year_clamp;
    ms_total    = MS_W'(hour_of_day) * HOUR_MS + MS_W'(minute_of_hour) * MINUTE_MS
                + MS_W'(milli_of_minute);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_year <= year_adj;
      s1_md   <= 10'(MONTH_TERM[month_number]) + 10'(day_of_month);
      s1_ms   <= ms_total;
    end
  end

  // stage 2: year term, century, whole day carry from time
  logic [14:0] year_sum;
  logic [24:0] year_prod;
  logic [25:0] cent_prod;
  logic [MS_W:0] ms_wide;
  logic          ms_over;

  always_comb begin
    year_sum  = {1'b0, s1_year} + YEAR_OFFSET;
    year_prod = 25'(year_sum) * DAYS_PER_4Y;
    cent_prod = 26'(s1_year) * CENTURY_RECIP;
    ms_wide   = {1'b0, s1_ms};
    ms_over   = ms_wide >= DAY_MS;
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s2_yterm <= year_prod[24:2];
      s2_cent  <= cent_prod[25:19];
      s2_md    <= s1_md;
      s2_whole <= ms_over;
      s2_rem   <= ms_over ? MS_W'(ms_wide - DAY_MS) : s1_ms;
    end
  end

  // stage 3: whole day count, remainder times the two reciprocal halves
  logic [23:0]      day_sum;
  logic [PLO_W-1:0] frac_lo;
  logic [PHI_W-1:0] frac_hi;

  always_comb begin
    day_sum = 24'(s2_yterm) + 24'(s2_md) + 24'(s2_cent[6:2]) + 24'(s2_whole)
            - 24'(s2_cent) - DAY_BIAS;
    frac_lo = PLO_W'(s2_rem) * RECIP_LO;
    frac_hi = PHI_W'(s2_rem) * RECIP_HI;
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s3_day <= day_sum[DAY_W-1:0];
      s3_plo <= frac_lo;
      s3_phi <= frac_hi;
    end
  end

  // stage 4: fraction of the day from the reciprocal product
  logic [PW-1:0] frac_sum;

  always_comb begin
    frac_sum = (PW'(s3_phi) << MLO_W) + PW'(s3_plo);
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s4_day  <= s3_day;
      s4_frac <= frac_sum[RECIP_SHIFT +: FRACTION_BITS];
    end
  end

  // last stage: join, remove the half day, saturate
  logic [VW-1:0] val;
  logic [CW-1:0] val_wide;

  always_comb begin
    val      = {s4_day, s4_frac} - (VW'(1) << (FRACTION_BITS - 1));
    val_wide = CW'(val);
  end

  always_ff @(posedge clk) begin
    if (en[NS-1]) begin
      out_data <= (val_wide > CW'(OUT_MAX)) ? OUT_MAX : val_wide[54:0];
    end
  end

endmodule

// ===== tb/sv/calendar_to_julian_date_unit_tb.sv =====
// directed and random timestamps through the julian date unit, checked beat by beat
`timescale 1ns / 1ps
module calendar_to_julian_date_unit_tb;
  import cjd_pkg::*;

  localparam int FRAC = 32;
  localparam int LATENCY = 4;
  localparam int QUIET_LIMIT = 2000;
  localparam int RANDOM_BEATS = 600;

  class jd_scoreboard;
    logic [54:0] expected_dates[$];
    int mismatches = 0;

    function logic [54:0] julian_date_of(logic [13:0] yr, logic [3:0] mo, logic [4:0] dy,
                                         logic [4:0] hr, logic [5:0] mi, logic [15:0] ms);
      longint y, m, d, cent, corr, days;
      longint unsigned tot, whole, rem, val;
      y = yr;
      m = mo;
      d = dy;
      if (y < 1) y = 1;
      if (y > 9999) y = 9999;
      // january and february belong to the previous year
      if (m >= 1 && m <= 2) begin
        y = y - 1;
        m = m + 12;
      end
      cent = y / 100;
      corr = 2 - cent + cent / 4;
      days = (1461 * (y + 4716)) / 4 + (306001 * (m + 1)) / 10000 + d + corr - 1524;
      tot = 64'(hr) * 64'd3600000 + 64'(mi) * 64'd60000 + 64'(ms);
      whole = tot / 64'd86400000;
      rem = tot % 64'd86400000;
      val = (unsigned'(days) + whole) << FRAC;
      val = val - (64'd1 << (FRAC - 1));
      val = val + (rem << (FRAC - 10)) / 64'd84375;
      if (val > 64'(OUT_MAX)) val = 64'(OUT_MAX);
      return val[54:0];
    endfunction

    function void note_timestamp(logic [13:0] yr, logic [3:0] mo, logic [4:0] dy,
                                 logic [4:0] hr, logic [5:0] mi, logic [15:0] ms);
      expected_dates.push_back(julian_date_of(yr, mo, dy, hr, mi, ms));
    endfunction

    function void check_date(logic [54:0] got);
      logic [54:0] want;
      if (expected_dates.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat: julian_date_fixed=%0h", got);
      end else begin
        want = expected_dates.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("julian_date_fixed mismatch: expected %0h, got %0h", want, got);
        end
      end
    endfunction
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [13:0] year_number = '0;
  logic [3:0]  month_number = '0;
  logic [4:0]  day_of_month = '0;
  logic [4:0]  hour_of_day = '0;
  logic [5:0]  minute_of_hour = '0;
  logic [15:0] milli_of_minute = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [54:0] julian_date_fixed;

  int send_idle = 9;
  int recv_idle = 56;
  int quiet = 0;
  jd_scoreboard sb = new();

  calendar_to_julian_date_unit #(.FRACTION_BITS(FRAC)) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .year_number(year_number),
    .month_number(month_number),
    .day_of_month(day_of_month),
    .hour_of_day(hour_of_day),
    .minute_of_hour(minute_of_hour),
    .milli_of_minute(milli_of_minute),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .julian_date_fixed(julian_date_fixed)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_date(julian_date_fixed);
    out_stall <= ($urandom_range(99) < recv_idle);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else if (quiet == QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic send_beat(input logic [13:0] yr, input logic [3:0] mo, input logic [4:0] dy,
                           input logic [4:0] hr, input logic [5:0] mi, input logic [15:0] ms);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    year_number <= yr;
    month_number <= mo;
    day_of_month <= dy;
    hour_of_day <= hr;
    minute_of_hour <= mi;
    milli_of_minute <= ms;
    do @(posedge clk); while (in_stall);
    sb.note_timestamp(yr, mo, dy, hr, mi, ms);
  endtask

  task automatic send_random_beat();
    if ($urandom_range(9) == 0) begin
      // raw bit patterns, out-of-range values included
      send_beat(14'($urandom), 4'($urandom), 5'($urandom), 5'($urandom), 6'($urandom),
                16'($urandom));
    end else begin
      send_beat(14'($urandom_range(9999, 1)), 4'($urandom_range(12, 1)),
                5'($urandom_range(31, 1)), 5'($urandom_range(23)), 6'($urandom_range(59)),
                16'($urandom_range(60999)));
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // year clamps, field extremes, century years, leap second, day carry
    send_beat(14'd0, 4'd1, 5'd1, 5'd0, 6'd0, 16'd0);
    send_beat(14'd1, 4'd1, 5'd1, 5'd0, 6'd0, 16'd0);
    send_beat(14'd9999, 4'd12, 5'd31, 5'd23, 6'd59, 16'd60999);
    send_beat(14'h3fff, 4'hf, 5'h1f, 5'h1f, 6'h3f, 16'hffff);
    send_beat(14'd2000, 4'd2, 5'd29, 5'd12, 6'd0, 16'd0);
    send_beat(14'd1900, 4'd3, 5'd1, 5'd0, 6'd0, 16'd0);
    send_beat(14'd1600, 4'd0, 5'd0, 5'd0, 6'd0, 16'd0);
    send_beat(14'd1582, 4'd10, 5'd15, 5'd0, 6'd0, 16'd0);
    for (int mo = 0; mo < 16; mo++)
      send_beat(14'($urandom_range(9999, 1)), 4'(mo), 5'($urandom_range(28, 1)),
                5'($urandom_range(23)), 6'($urandom_range(59)), 16'($urandom_range(59999)));

    repeat (RANDOM_BEATS) send_random_beat();
    send_idle = 56;
    recv_idle = 9;
    repeat (RANDOM_BEATS) send_random_beat();
    send_idle = 0;
    recv_idle = 0;
    repeat (RANDOM_BEATS) send_random_beat();
    in_valid <= 1'b0;

    while (sb.expected_dates.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
